// ===== hdl/timer_slot_bank_top_defines.svh =====
// Assertion macros shared by the checker of the timer slot bank.
`ifndef TIMER_SLOT_BANK_TOP_DEFINES_SVH
`define TIMER_SLOT_BANK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tsb_pkg.sv =====
package tsb_pkg;

    localparam int SLOTS      = 16;
    localparam int TAG_BITS   = 16;
    localparam int COUNT_BITS = 32;
    localparam int SLOT_BITS  = 4;

    // Most negative count; a decrement saturates here.
    localparam logic [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                          op;
        logic [TAG_BITS-1:0]          tag;
        logic                         has_arg;
        logic signed [COUNT_BITS-1:0] delay;
    } t_in_item;

    typedef struct packed {
        t_kind                kind;
        logic [SLOT_BITS-1:0] slot;
        logic [TAG_BITS-1:0]  fired_tag;
        logic                 fired_has_arg;
        logic                 last;
        logic                 table_empty;
    } t_out_item;

    // Operation token that walks down the row of slot cells.
    typedef struct packed {
        logic                   valid;
        t_op                    op;
        logic                   looking;
        logic [TAG_BITS-1:0]    tag;
        logic                   has_arg;
        logic [COUNT_BITS-1:0]  delay;
    } t_token;

    // What a cell reports while it holds the token.
    typedef struct packed {
        logic                hit;
        logic [TAG_BITS-1:0] tag;
        logic                has_arg;
    } t_event;

endpackage

// ===== hdl/tsb_cell.sv =====
module tsb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsb_pkg::t_token i_tok,
    output tsb_pkg::t_token o_tok,
    output tsb_pkg::t_event o_event,
    output logic            o_free_after_tick
);

    logic                           r_free;
    logic                           n_free;
    logic [tsb_pkg::COUNT_BITS-1:0] r_count;
    logic [tsb_pkg::COUNT_BITS-1:0] n_count;
    logic [tsb_pkg::TAG_BITS-1:0]   r_tag;
    logic [tsb_pkg::TAG_BITS-1:0]   n_tag;
    logic                           r_arg;
    logic                           n_arg;
    tsb_pkg::t_token                r_tok;
    tsb_pkg::t_token                n_tok;
    logic [tsb_pkg::COUNT_BITS-1:0] w_dec;
    logic                           w_expire;

    // Saturating decrement and the zero-or-below test.
    always_comb begin
        w_dec    = (r_count == tsb_pkg::COUNT_MIN) ? r_count
                                                   : r_count - tsb_pkg::COUNT_BITS'(1);
        w_expire = w_dec[tsb_pkg::COUNT_BITS-1] | (w_dec == '0);
    end

    // A slot ends a tick free if it is free now or it fires on this tick.
    assign o_free_after_tick = r_free | w_expire;

    // Act on the token while this cell holds it, then pass it on.
    always_comb begin
        n_free  = r_free;
        n_count = r_count;
        n_tag   = r_tag;
        n_arg   = r_arg;
        n_tok   = i_tok;
        o_event = '0;
        if (i_tok.valid) begin
            if (i_tok.op == tsb_pkg::OP_ADD) begin
                if (i_tok.looking && r_free) begin
                    n_free        = 1'b0;
                    n_count       = i_tok.delay;
                    n_tag         = i_tok.tag;
                    n_arg         = i_tok.has_arg;
                    n_tok.looking = 1'b0;
                    o_event.hit   = 1'b1;
                end
            end else if (!r_free) begin
                if (w_expire) begin
                    n_free          = 1'b1;
                    o_event.hit     = 1'b1;
                    o_event.tag     = r_tag;
                    o_event.has_arg = r_arg;
                end else begin
                    n_count = w_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_tag   <= n_tag;
        if (!i_rst_n) begin
            r_free <= 1'b1;
            r_arg  <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_free <= n_free;
            r_arg  <= n_arg;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/timer_slot_bank_top.sv =====
// Each item occupies the bank from its accepting edge until busy falls again: busy stays high
// while an operation token walks the 16 cells, and no new item is taken until then.
// Results leave at most one per cycle, in slot order; the last one is on the outputs
// together with the fall of busy.
// The receiver cannot stall; each result is shown for exactly one cycle under o_valid.
// Synchronous active-low reset frees every slot and drops busy and o_valid.
module timer_slot_bank_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  tsb_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_valid,
    output tsb_pkg::t_out_item  o_result
);

    tsb_pkg::t_token            w_tok [0:tsb_pkg::SLOTS];
    tsb_pkg::t_event            w_event [0:tsb_pkg::SLOTS-1];
    logic [tsb_pkg::SLOTS-1:0]  w_free_after;
    logic                       w_accept;
    logic                       w_hit;
    tsb_pkg::t_out_item         w_hit_item;

    logic                       r_busy;
    logic                       n_busy;
    tsb_pkg::t_token            r_inj;
    tsb_pkg::t_token            n_inj;
    tsb_pkg::t_op               r_op;
    tsb_pkg::t_op               n_op;
    logic                       r_empty;
    logic                       n_empty;
    logic                       r_pend_valid;
    logic                       n_pend_valid;
    tsb_pkg::t_out_item         r_pend;
    tsb_pkg::t_out_item         n_pend;
    logic                       r_out_valid;
    logic                       n_out_valid;
    tsb_pkg::t_out_item         r_out;
    tsb_pkg::t_out_item         n_out;

    assign w_accept = start & ~r_busy;
    assign w_tok[0] = r_inj;

    // Row of slot cells; the token moves one cell per cycle.
    for (genvar g = 0; g < tsb_pkg::SLOTS; g++) begin : g_cell
        tsb_cell u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_tok             (w_tok[g]),
            .o_tok             (w_tok[g+1]),
            .o_event           (w_event[g]),
            .o_free_after_tick (w_free_after[g])
        );
    end

    // Only the cell holding the token can report, so this picks at most one.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_item = '0;
        for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
            if (w_event[i].hit) begin
                w_hit                    = 1'b1;
                w_hit_item.kind          = (r_op == tsb_pkg::OP_ADD) ? tsb_pkg::KIND_ADD_OK
                                                                     : tsb_pkg::KIND_FIRED;
                w_hit_item.slot          = tsb_pkg::SLOT_BITS'(i);
                w_hit_item.fired_tag     = w_event[i].tag;
                w_hit_item.fired_has_arg = w_event[i].has_arg;
                w_hit_item.last          = 1'b0;
                w_hit_item.table_empty   = r_empty;
            end
        end
    end

    // Control: start a scan, hold one result back to learn whether it is the last.
    always_comb begin
        n_busy       = r_busy;
        n_op         = r_op;
        n_empty      = r_empty;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        n_inj        = '0;

        if (w_accept) begin
            n_busy        = 1'b1;
            n_op          = i_item.op;
            // An add always leaves at least one busy slot: the claimed one or a full table.
            n_empty       = (i_item.op == tsb_pkg::OP_ADD) ? 1'b0 : (&w_free_after);
            n_inj.valid   = 1'b1;
            n_inj.op      = i_item.op;
            n_inj.looking = 1'b1;
            n_inj.tag     = i_item.tag;
            n_inj.has_arg = i_item.has_arg;
            n_inj.delay   = i_item.delay;
        end

        if (w_hit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_pend;
            end
            n_pend_valid = 1'b1;
            n_pend       = w_hit_item;
        end

        // The token has left the last cell: close the item.
        if (w_tok[tsb_pkg::SLOTS].valid) begin
            n_busy       = 1'b0;
            n_pend_valid = 1'b0;
            n_out_valid  = 1'b1;
            if (r_pend_valid) begin
                n_out      = r_pend;
                n_out.last = 1'b1;
            end else begin
                n_out             = '0;
                n_out.kind        = (r_op == tsb_pkg::OP_ADD) ? tsb_pkg::KIND_ADD_FULL
                                                              : tsb_pkg::KIND_NONE;
                n_out.last        = 1'b1;
                n_out.table_empty = r_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_empty <= n_empty;
        r_pend  <= n_pend;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_inj        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_inj        <= n_inj;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/tsb_checker.sv =====
`include "timer_slot_bank_top_defines.svh"

module tsb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input tsb_pkg::t_out_item o_result
);

    logic w_add_result;
    logic w_plain_result;
    logic w_no_tag;

    // Results of an add, whether it claimed a slot or was turned away.
    assign w_add_result = o_valid && (o_result.kind == tsb_pkg::KIND_ADD_OK ||
                                      o_result.kind == tsb_pkg::KIND_ADD_FULL);

    // Results that do not come from a fired timer.
    assign w_plain_result = o_valid && (o_result.kind != tsb_pkg::KIND_FIRED);
    assign w_no_tag       = (o_result.fired_tag == '0) && !o_result.fired_has_arg;

    // An accepted item makes the bank busy on the next cycle.
    `TSB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "not busy after accept")

    // The closing result of an item comes with busy already low.
    `TSB_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_valid && o_result.last, !busy, "busy on last")

    // An add gives exactly one result.
    `TSB_ASSERT_NOW(a_add_single, i_clk, i_rst_n, w_add_result, o_result.last, "add not last")

    // Only a fired timer carries a tag and a with-argument mark.
    `TSB_ASSERT_NOW(a_tag_zero, i_clk, i_rst_n, w_plain_result, w_no_tag, "stray tag")

endmodule

bind timer_slot_bank_top tsb_checker u_tsb_checker (.*);

// ===== dv/timer_slot_bank_top_test.sv =====
module timer_slot_bank_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    tsb_pkg::t_in_item  i_item;
    logic               busy;
    logic               o_valid;
    tsb_pkg::t_out_item o_result;

    timer_slot_bank_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Predicted contents of the timer bank.
    logic                                  slot_busy [tsb_pkg::SLOTS];
    logic signed [tsb_pkg::COUNT_BITS-1:0] slot_count [tsb_pkg::SLOTS];
    logic [tsb_pkg::TAG_BITS-1:0]          slot_tag [tsb_pkg::SLOTS];
    logic                                  slot_arg [tsb_pkg::SLOTS];

    tsb_pkg::t_out_item pending_results[$];

    int  error_count;
    int  items_sent;
    int  fired_seen;
    int  rejects_seen;
    int  quiet_ticks_seen;
    int  idle_cycles;
    bit  burst_mode;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the results of one accepted item and update the predicted bank.
    function automatic void predict_bank_step(input tsb_pkg::t_in_item it);
        tsb_pkg::t_out_item batch[$];
        tsb_pkg::t_out_item res;
        int                 found;
        bit                 all_free;
        found = -1;
        if (it.op == tsb_pkg::OP_ADD) begin
            for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
                if (!slot_busy[i] && found < 0) found = i;
            end
            res = '0;
            if (found < 0) begin
                res.kind = tsb_pkg::KIND_ADD_FULL;
            end else begin
                slot_busy[found]  = 1'b1;
                slot_count[found] = it.delay;
                slot_tag[found]   = it.tag;
                slot_arg[found]   = it.has_arg;
                res.kind = tsb_pkg::KIND_ADD_OK;
                res.slot = found[tsb_pkg::SLOT_BITS-1:0];
            end
            batch.push_back(res);
        end else begin
            for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
                if (slot_busy[i]) begin
                    if (slot_count[i] != tsb_pkg::COUNT_MIN) slot_count[i] = slot_count[i] - 1;
                    if (slot_count[i] <= 0) begin
                        res = '0;
                        res.kind          = tsb_pkg::KIND_FIRED;
                        res.slot          = i[tsb_pkg::SLOT_BITS-1:0];
                        res.fired_tag     = slot_tag[i];
                        res.fired_has_arg = slot_arg[i];
                        batch.push_back(res);
                        slot_busy[i] = 1'b0;
                    end
                end
            end
            if (batch.size() == 0) begin
                res = '0;
                res.kind = tsb_pkg::KIND_NONE;
                batch.push_back(res);
            end
        end
        all_free = 1'b1;
        for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
            if (slot_busy[i]) all_free = 1'b0;
        end
        foreach (batch[k]) begin
            batch[k].table_empty = all_free;
            batch[k].last        = (k == batch.size() - 1);
            pending_results.push_back(batch[k]);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Result checker and predictor; results are checked before a new item is predicted.
    always @(posedge i_clk) begin
        tsb_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, o_result);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(o_result.kind));
                    compare_field("slot", 32'(want.slot), 32'(o_result.slot));
                    compare_field("fired_tag", 32'(want.fired_tag), 32'(o_result.fired_tag));
                    compare_field("fired_has_arg", 32'(want.fired_has_arg),
                                  32'(o_result.fired_has_arg));
                    compare_field("last", 32'(want.last), 32'(o_result.last));
                    compare_field("table_empty", 32'(want.table_empty),
                                  32'(o_result.table_empty));
                    case (want.kind)
                        tsb_pkg::KIND_FIRED:    fired_seen++;
                        tsb_pkg::KIND_ADD_FULL: rejects_seen++;
                        tsb_pkg::KIND_NONE:     quiet_ticks_seen++;
                        default: ;
                    endcase
                end
            end
            if (start && !busy) predict_bank_step(i_item);
        end
    end

    // Watchdog on cycles in which neither an item nor a result is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_results.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one item after a random gap, then wait until the bank takes it.
    task automatic send_item(input tsb_pkg::t_op op, input logic [tsb_pkg::TAG_BITS-1:0] tag,
                             input logic has_arg,
                             input logic signed [tsb_pkg::COUNT_BITS-1:0] delay);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_item.op      <= op;
        i_item.tag     <= tag;
        i_item.has_arg <= has_arg;
        i_item.delay   <= delay;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Stop offering items, then wait until every predicted result has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // A tick on an empty bank reports that nothing fired.
    task automatic test_empty_tick();
        send_item(tsb_pkg::OP_TICK, 16'hFFFF, 1'b1, 32'sh7FFF_FFFF);
    endtask

    // Fill every slot with due timers, overflow the bank, then fire all sixteen at once.
    task automatic test_fill_and_flush();
        logic signed [tsb_pkg::COUNT_BITS-1:0] d;
        for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
            case (i % 4)
                0: d = tsb_pkg::COUNT_MIN;
                1: d = 0;
                2: d = -1;
                default: d = 1;
            endcase
            send_item(tsb_pkg::OP_ADD, (i % 2 == 1) ? 16'hFFFF : 16'(i), 1'(i % 2), d);
        end
        send_item(tsb_pkg::OP_ADD, 16'hA5A5, 1'b1, 5);
        send_item(tsb_pkg::OP_TICK, 16'h0000, 1'b0, 0);
    endtask

    // A timer of two ticks stays quiet on the first tick and fires on the second.
    task automatic test_delayed_fire();
        send_item(tsb_pkg::OP_ADD, 16'h1234, 1'b1, 2);
        send_item(tsb_pkg::OP_TICK, 16'h0, 1'b0, 0);
        send_item(tsb_pkg::OP_TICK, 16'h0, 1'b0, 0);
    endtask

    // Mostly small delays so slots fill and drain; some negative and saturating delays.
    task automatic test_random_traffic(input int count);
        logic signed [tsb_pkg::COUNT_BITS-1:0] d;
        int                                    sel;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (n == count / 2) begin
                burst_mode = 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 45) begin
                send_item(tsb_pkg::OP_TICK, 16'($urandom), 1'($urandom), $urandom);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    d = $urandom_range(0, 10);
                    d = d - 2;
                end else if (sel < 9) begin
                    d = $urandom | 32'h8000_0000;
                end else begin
                    d = tsb_pkg::COUNT_MIN;
                end
                send_item(tsb_pkg::OP_ADD, 16'($urandom), 1'($urandom), d);
            end
        end
        burst_mode = 1'b0;
    endtask

    // The longest delay never expires within the run; it is added last on purpose.
    task automatic test_longest_delay();
        send_item(tsb_pkg::OP_ADD, 16'hFFFF, 1'b1, 32'sh7FFF_FFFF);
        send_item(tsb_pkg::OP_TICK, 16'h0, 1'b0, 0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_item           = '0;
        error_count      = 0;
        items_sent       = 0;
        fired_seen       = 0;
        rejects_seen     = 0;
        quiet_ticks_seen = 0;
        idle_cycles      = 0;
        burst_mode       = 1'b0;
        for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_count[i] = '0;
            slot_tag[i]   = '0;
            slot_arg[i]   = 1'b0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_tick();
        test_fill_and_flush();
        test_delayed_fire();
        test_random_traffic(325);
        test_longest_delay();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d items through the bank: %0d timers fired, %0d adds rejected,",
                 items_sent, fired_seen, rejects_seen);
        $display("%0d ticks with nothing due, with random gaps and back-to-back bursts.",
                 quiet_ticks_seen);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== timer_slot_bank_top.f =====
+incdir+hdl
hdl/tsb_pkg.sv
hdl/tsb_cell.sv
hdl/timer_slot_bank_top.sv
hdl/tsb_checker.sv
dv/timer_slot_bank_top_test.sv
